// ===== rtl/dqsvm_pkg.sv =====
// ----------------------------------------------------------------------------
// dqsvm_pkg
// Shared types, constants and helper functions of the d/q to SVPWM modulator.
// ----------------------------------------------------------------------------
package dqsvm_pkg;

  localparam int VOLT_WIDTH = 16;   // voltage command field width
  localparam int VOLT_FRAC  = 4;    // fractional bits of alpha/beta
  localparam int DUTY_W     = 16;   // compare count width
  localparam int BUS_W      = 15;
  localparam int PWM_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SQRT3_Q14   = 28378;
  localparam int THREE_Q14   = 3 * 16384;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [BUS_W-1:0] BUS_RESET = 15'd24576;
  localparam logic [PWM_W-1:0] PWM_RESET = 16'd10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUS_VOLTAGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_FULL_SCALE = 2'd1;

  // sector numbers
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;

  typedef struct packed {
    logic        [15:0] angle;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [2:0]        sector;
    logic              overmodulated;
  } out_item_t;

  // comparison pattern {x-y>=0, beta>=0, -x-y>=0} to sector
  function automatic logic [2:0] sector_of_pattern(input logic [2:0] pat);
    logic [2:0] sec;
    unique case (pat)
      3'd0, 3'd1: sec = SEC_4;
      3'd2:       sec = SEC_2;
      3'd3:       sec = SEC_3;
      3'd4:       sec = SEC_6;
      3'd5:       sec = SEC_5;
      default:    sec = SEC_1;
    endcase
    return sec;
  endfunction

  // Q30 Taylor sine of a 32-bit phase, rounded to fb fractional bits.
  // Elaboration only: builds the constant table.
  function automatic longint sine_of_phase(input logic [31:0] ph, input int fb);
    logic [1:0]      quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned q;
    longint          s;
    quad = ph[31:30];
    r    = 64'(ph[29:0]);
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x  = (r * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = x;
    s  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > (64'sd1 <<< 30)) begin
      s = 64'sd1 <<< 30;
    end
    q = (64'(s) + (64'd1 << (29 - fb))) >> (30 - fb);
    return (quad >= 2'd2) ? -longint'(q) : longint'(q);
  endfunction

endpackage

// ===== rtl/dq_to_svm_duty_modulator_core.sv =====
// ----------------------------------------------------------------------------
// dq_to_svm_duty_modulator_core
// Inverse Park/Clarke plus space-vector PWM duty generation, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | transaction when
//  ---------+-----------------------------------------+-----------------------------
//  command  | start, busy, in_data                    | start high, busy low
//  result   | out_strobe, out_data                    | out_strobe high (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready high
//
//  Throughput: one command per clock; busy is always low.
//  Pipeline: nine arithmetic stages, then a 16-stage restoring divider (one
//    quotient bit per stage) for the three compare counts, then the output
//    register.
//  Reset: synchronous active-low rst_n clears all valid bits and loads the
//    register defaults (bus 24576, full scale 10000).
//  Stalls: none. The receiver cannot stall, so the pipeline always advances.
//  Config is sampled in-flight at stages 7 and 8; write only while idle.
//
module dq_to_svm_duty_modulator_core #(
  parameter int TABLE_DEPTH    = 256,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  dqsvm_pkg::in_item_t                    in_data,
  output logic                                   out_strobe,
  output dqsvm_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dqsvm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dqsvm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dqsvm_pkg::*;

  // ---- derived widths ------------------------------------------------------
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TW     = TRIG_FRAC_BITS + 2;        // table entry, signed
  localparam int PW     = TW + 1 + 17;               // interpolation product
  localparam int MW     = VOLT_WIDTH + TW;           // rotation products
  localparam int SH     = TRIG_FRAC_BITS - VOLT_FRAC;
  localparam int AB_W   = VOLT_WIDTH + 6;            // alpha/beta
  localparam int XY_W   = AB_W + 16;                 // scaled alpha/beta
  localparam int N_W    = XY_W + 2;                  // sector numerators
  localparam int NUM_W  = N_W + 1;                   // edge numerators, unsigned
  localparam int SPLIT  = (NUM_W + 1) / 2;
  localparam int PPL_W  = PWM_W + SPLIT;
  localparam int PPH_W  = PWM_W + NUM_W - SPLIT;
  localparam int DV_W   = NUM_W + PWM_W + 1;         // dividend
  localparam int D2_W   = N_W + 1;                   // 2 * denominator
  localparam int DEN_SH = VOLT_FRAC + 15;
  localparam int NSTG   = DUTY_W;

  localparam logic [IDX_W-1:0] QTR = IDX_W'(TABLE_DEPTH / 4);

  localparam int EDGE_LO  = 0;
  localparam int EDGE_MID = 1;
  localparam int EDGE_HI  = 2;

  localparam logic signed [PW-1:0]  INT_HALF = PW'(32768);
  localparam logic signed [MW:0]    ROT_HALF = (MW + 1)'(1) <<< (SH - 1);
  localparam logic signed [XY_W-1:0] K_X = XY_W'(THREE_Q14);
  localparam logic signed [XY_W-1:0] K_Y = XY_W'(SQRT3_Q14);

  // ---- sine table ----------------------------------------------------------
  typedef logic signed [TW-1:0] trig_tab_t [TABLE_DEPTH];

  function automatic trig_tab_t build_sine();
    trig_tab_t tb;
    logic [31:0] ph;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      ph    = 32'(k) << (32 - IDX_W);
      tb[k] = TW'(sine_of_phase(ph, TRIG_FRAC_BITS));
    end
    return tb;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sine();

  // ---- handshake / config --------------------------------------------------
  logic             in_acc;
  logic [BUS_W-1:0] bus_r;
  logic [PWM_W-1:0] pwm_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= BUS_RESET;
      pwm_r <= PWM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BUS_VOLTAGE) begin
        bus_r <= cfg_data[BUS_W-1:0];
      end else if (cfg_index == REG_PWM_FULL_SCALE) begin
        pwm_r <= cfg_data[PWM_W-1:0];
      end
    end
  end

  // ---- stage 1: table lookup -----------------------------------------------
  logic [IDX_W-1:0] idx, nxt;
  logic [15:0]      frac;

  logic                    s1_vld_r;
  logic signed [TW-1:0]    s1_sn0_r, s1_sn1_r, s1_cs0_r, s1_cs1_r;
  logic [15:0]             s1_frac_r;
  logic signed [15:0]      s1_vd_r, s1_vq_r;

  assign idx  = in_data.angle[15 -: IDX_W];
  assign nxt  = idx + IDX_W'(1);            // wraps after the last entry
  assign frac = in_data.angle << IDX_W;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    s1_sn0_r  <= SIN_TAB[idx];
    s1_sn1_r  <= SIN_TAB[nxt];
    s1_cs0_r  <= SIN_TAB[idx + QTR];        // cosine is sine a quarter turn on
    s1_cs1_r  <= SIN_TAB[nxt + QTR];
    s1_frac_r <= frac;
    s1_vd_r   <= in_data.volt_d;
    s1_vq_r   <= in_data.volt_q;
  end

  // ---- stage 2: linear interpolation ---------------------------------------
  logic signed [PW-1:0] sn_p, cs_p, frac_s;
  logic signed [TW-1:0] sn_nxt, cs_nxt;

  logic                 s2_vld_r;
  logic signed [TW-1:0] s2_sn_r, s2_cs_r;
  logic signed [15:0]   s2_vd_r, s2_vq_r;

  always_comb begin
    frac_s = PW'($signed({1'b0, s1_frac_r}));
    sn_p   = (PW'(s1_sn1_r) - PW'(s1_sn0_r)) * frac_s;
    cs_p   = (PW'(s1_cs1_r) - PW'(s1_cs0_r)) * frac_s;
    sn_nxt = s1_sn0_r + TW'((sn_p + INT_HALF) >>> 16);
    cs_nxt = s1_cs0_r + TW'((cs_p + INT_HALF) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_sn_r <= sn_nxt;
    s2_cs_r <= cs_nxt;
    s2_vd_r <= s1_vd_r;
    s2_vq_r <= s1_vq_r;
  end

  // ---- stage 3: rotation products ------------------------------------------
  logic                 s3_vld_r;
  logic signed [MW-1:0] s3_dc_r, s3_qs_r, s3_qc_r, s3_ds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    s3_dc_r <= MW'(s2_vd_r) * MW'(s2_cs_r);
    s3_qs_r <= MW'(s2_vq_r) * MW'(s2_sn_r);
    s3_qc_r <= MW'(s2_vq_r) * MW'(s2_cs_r);
    s3_ds_r <= MW'(s2_vd_r) * MW'(s2_sn_r);
  end

  // ---- stage 4: alpha / beta, rounded to VOLT_FRAC bits --------------------
  logic signed [MW:0]     al_w, be_w;
  logic                   s4_vld_r;
  logic signed [AB_W-1:0] s4_al_r, s4_be_r;

  always_comb begin
    al_w = (MW + 1)'(s3_dc_r) - (MW + 1)'(s3_qs_r) + ROT_HALF;
    be_w = (MW + 1)'(s3_qc_r) + (MW + 1)'(s3_ds_r) + ROT_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    s4_al_r <= AB_W'(al_w >>> SH);
    s4_be_r <= AB_W'(be_w >>> SH);
  end

  // ---- stage 5: x = 3*alpha, y = sqrt3*beta (Q14) ---------------------------
  logic                   s5_vld_r;
  logic signed [XY_W-1:0] s5_x_r, s5_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    s5_x_r <= XY_W'(s4_al_r) * K_X;
    s5_y_r <= XY_W'(s4_be_r) * K_Y;
  end

  // ---- stage 6: sector and numerators --------------------------------------
  logic signed [N_W-1:0] xe, ye, xmy, nxy, n1, n2;
  logic [2:0]            pat, sec;

  logic                  s6_vld_r;
  logic [2:0]            s6_sec_r;
  logic signed [N_W-1:0] s6_n1_r, s6_s_r;

  always_comb begin
    xe  = N_W'(s5_x_r);
    ye  = N_W'(s5_y_r);
    xmy = xe - ye;
    nxy = -xe - ye;
    pat = {~xmy[N_W-1], ~ye[N_W-1], ~nxy[N_W-1]};
    sec = sector_of_pattern(pat);
    unique case (sec)
      SEC_1: begin n1 = xmy;      n2 = ye <<< 1;  end
      SEC_2: begin n1 = ye - xe;  n2 = xe + ye;   end
      SEC_3: begin n1 = ye <<< 1; n2 = nxy;       end
      SEC_4: begin n1 = -(ye <<< 1); n2 = ye - xe; end
      SEC_5: begin n1 = nxy;      n2 = xmy;       end
      default: begin n1 = xe + ye; n2 = -(ye <<< 1); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
  end

  always_ff @(posedge clk) begin
    s6_sec_r <= sec;
    s6_n1_r  <= n1;
    s6_s_r   <= n1 + n2;
  end

  // ---- stage 7: overmodulation check and edge numerators -------------------
  logic [BUS_W-1:0]      bus_eff;
  logic signed [N_W-1:0] den_c, den_e;
  logic                  over;
  logic [NUM_W-1:0]      lo_n;

  logic                  s7_vld_r;
  logic [2:0]            s7_sec_r;
  logic                  s7_ovr_r;
  logic signed [N_W-1:0] s7_den_r;
  logic [NUM_W-1:0]      s7_num_r [3];

  always_comb begin
    bus_eff = (bus_r == '0) ? BUS_W'(1) : bus_r;
    den_c   = $signed(N_W'({bus_eff, {DEN_SH{1'b0}}}));
    over    = s6_s_r > den_c;
    den_e   = over ? s6_s_r : den_c;
    lo_n    = NUM_W'(den_e) - NUM_W'(s6_s_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else        s7_vld_r <= s6_vld_r;
  end

  always_ff @(posedge clk) begin
    s7_sec_r           <= s6_sec_r;
    s7_ovr_r           <= over;
    s7_den_r           <= den_e;
    s7_num_r[EDGE_LO]  <= lo_n;
    s7_num_r[EDGE_MID] <= lo_n + (NUM_W'(s6_n1_r) << 1);
    s7_num_r[EDGE_HI]  <= NUM_W'(den_e) + NUM_W'(s6_s_r);
  end

  // ---- stage 8: full scale times numerator, split in two partial products --
  logic                  s8_vld_r;
  logic [2:0]            s8_sec_r;
  logic                  s8_ovr_r;
  logic signed [N_W-1:0] s8_den_r;
  logic [PPL_W-1:0]      s8_ppl_r [3];
  logic [PPH_W-1:0]      s8_pph_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else        s8_vld_r <= s7_vld_r;
  end

  always_ff @(posedge clk) begin
    s8_sec_r <= s7_sec_r;
    s8_ovr_r <= s7_ovr_r;
    s8_den_r <= s7_den_r;
    for (int k = 0; k < 3; k++) begin
      s8_ppl_r[k] <= PPL_W'(pwm_r) * PPL_W'(s7_num_r[k][SPLIT-1:0]);
      s8_pph_r[k] <= PPH_W'(pwm_r) * PPH_W'(s7_num_r[k][NUM_W-1:SPLIT]);
    end
  end

  // ---- stage 9 + divider: count = floor((P*num + den) / (2*den)) -----------
  // Index 0 of the divider arrays is stage 9; index g+1 holds the result of
  // quotient bit (NSTG-1-g).
  logic              dv_vld_r  [NSTG+1];
  logic [2:0]        dv_sec_r  [NSTG+1];
  logic              dv_ovr_r  [NSTG+1];
  logic [D2_W-1:0]   dv_den2_r [NSTG+1];
  logic [DV_W-1:0]   dv_rem_r  [NSTG+1][3];
  logic [DUTY_W-1:0] dv_q_r    [NSTG+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= s8_vld_r;
  end

  always_ff @(posedge clk) begin
    dv_sec_r[0]  <= s8_sec_r;
    dv_ovr_r[0]  <= s8_ovr_r;
    dv_den2_r[0] <= D2_W'($unsigned(s8_den_r)) << 1;
    for (int k = 0; k < 3; k++) begin
      dv_rem_r[0][k] <= (DV_W'(s8_pph_r[k]) << SPLIT) + DV_W'(s8_ppl_r[k])
                        + DV_W'($unsigned(s8_den_r));
      dv_q_r[0][k]   <= '0;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_div
    logic [DV_W-1:0] trial;
    logic [DV_W-1:0] rem_nxt [3];
    logic [2:0]      bit_nxt;

    always_comb begin
      trial = DV_W'(dv_den2_r[g]) << (NSTG - 1 - g);
      for (int k = 0; k < 3; k++) begin
        bit_nxt[k] = dv_rem_r[g][k] >= trial;
        rem_nxt[k] = bit_nxt[k] ? (dv_rem_r[g][k] - trial) : dv_rem_r[g][k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[g+1] <= 1'b0;
      else        dv_vld_r[g+1] <= dv_vld_r[g];
    end

    always_ff @(posedge clk) begin
      dv_sec_r[g+1]  <= dv_sec_r[g];
      dv_ovr_r[g+1]  <= dv_ovr_r[g];
      dv_den2_r[g+1] <= dv_den2_r[g];
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[g+1][k] <= rem_nxt[k];
        dv_q_r[g+1][k]   <= {dv_q_r[g][k][DUTY_W-2:0], bit_nxt[k]};
      end
    end
  end

  // ---- output: assign edges to phases by sector ----------------------------
  logic [DUTY_W-1:0] e_lo, e_mid, e_hi;
  out_item_t         res;
  logic              out_strobe_r;
  out_item_t         out_data_r;

  always_comb begin
    e_lo              = dv_q_r[NSTG][EDGE_LO];
    e_mid             = dv_q_r[NSTG][EDGE_MID];
    e_hi              = dv_q_r[NSTG][EDGE_HI];
    res.sector        = dv_sec_r[NSTG];
    res.overmodulated = dv_ovr_r[NSTG];
    unique case (dv_sec_r[NSTG])
      SEC_1: begin res.duty_a = e_lo;  res.duty_b = e_mid; res.duty_c = e_hi;  end
      SEC_2: begin res.duty_a = e_mid; res.duty_b = e_lo;  res.duty_c = e_hi;  end
      SEC_3: begin res.duty_a = e_hi;  res.duty_b = e_lo;  res.duty_c = e_mid; end
      SEC_4: begin res.duty_a = e_hi;  res.duty_b = e_mid; res.duty_c = e_lo;  end
      SEC_5: begin res.duty_a = e_mid; res.duty_b = e_hi;  res.duty_c = e_lo;  end
      default: begin res.duty_a = e_lo; res.duty_b = e_hi; res.duty_c = e_mid; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= dv_vld_r[NSTG];
  end

  always_ff @(posedge clk) begin
    out_data_r <= res;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the d/q to SVPWM duty modulator. A scoreboard
// predicts each command's duties, sector and overmodulation flag and checks
// every strobed result in order, across several bus/full-scale settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dqsvm_pkg::*;

  localparam int TAB_N      = 256;
  localparam int TRIG_FB    = 15;
  localparam int PIPE_DRAIN = 40;       // idle margin after the last expected result
  localparam int CYCLE_MAX  = 400000;

  // --------------------------------------------------------------------------
  // Scoreboard: duty predictor plus queue of expected results
  // --------------------------------------------------------------------------
  class duty_scoreboard;
    longint          sin_tab[TAB_N];
    longint          cos_tab[TAB_N];
    longint unsigned bus_v;
    longint unsigned full_scale;
    out_item_t       duty_q[$];
    int              n_cmd;
    int              n_over;
    int              sec_seen[8];

    function new();
      for (int k = 0; k < TAB_N; k++) begin
        sin_tab[k] = taylor_sine(32'(k) << 24);
        cos_tab[k] = taylor_sine((32'(k) << 24) + 32'h4000_0000);
      end
      bus_v      = 64'(BUS_RESET);
      full_scale = 64'(PWM_RESET);
    endfunction

    // Q30 Taylor series, quadrant folded, rounded to TRIG_FB bits
    function longint taylor_sine(input logic [31:0] ph);
      longint unsigned r, x, x2, t, q;
      longint          acc;
      r = 64'(ph[29:0]);
      if (ph[30]) begin
        r = (64'd1 << 30) - r;
      end
      x   = (r * 64'd1686629713 + (64'd1 << 29)) >> 30;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      t   = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      q = (64'(acc) + (64'd1 << (29 - TRIG_FB))) >> (30 - TRIG_FB);
      return ph[31] ? -longint'(q) : longint'(q);
    endfunction

    // floor(v / 2^sh + 1/2)
    function longint round_sh(input longint v, input int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function longint unsigned count_of(input longint unsigned num,
                                       input longint unsigned den);
      return (full_scale * num + den) / (2 * den);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_BUS_VOLTAGE) bus_v = 64'(val[BUS_W-1:0]);
      else if (idx == REG_PWM_FULL_SCALE) full_scale = 64'(val);
    endfunction

    function void note_command(input in_item_t cmd);
      logic [7:0]      i0, i1;
      longint          fr, sn, cs, vd, vq, al, be, x, y, n1, n2, s, den;
      longint unsigned bus, lo, mid, hi;
      logic [2:0]      pat;
      out_item_t       res;
      i0 = cmd.angle[15:8];
      i1 = i0 + 8'd1;                          // wraps after last entry
      fr = longint'({cmd.angle[7:0], 8'h00});
      sn = sin_tab[i0] + round_sh((sin_tab[i1] - sin_tab[i0]) * fr, 16);
      cs = cos_tab[i0] + round_sh((cos_tab[i1] - cos_tab[i0]) * fr, 16);
      vd = longint'(cmd.volt_d);
      vq = longint'(cmd.volt_q);
      al = round_sh(vd * cs - vq * sn, TRIG_FB - VOLT_FRAC);
      be = round_sh(vq * cs + vd * sn, TRIG_FB - VOLT_FRAC);
      x  = al * THREE_Q14;
      y  = be * SQRT3_Q14;
      pat = {(x - y >= 0), (be >= 0), (-x - y >= 0)};
      case (pat)
        3'd2:    res.sector = SEC_2;
        3'd3:    res.sector = SEC_3;
        3'd4:    res.sector = SEC_6;
        3'd5:    res.sector = SEC_5;
        3'd6,
        3'd7:    res.sector = SEC_1;
        default: res.sector = SEC_4;
      endcase
      case (res.sector)
        SEC_1:   begin n1 = x - y;  n2 = 2 * y;  end
        SEC_2:   begin n1 = y - x;  n2 = x + y;  end
        SEC_3:   begin n1 = 2 * y;  n2 = -x - y; end
        SEC_4:   begin n1 = -2 * y; n2 = y - x;  end
        SEC_5:   begin n1 = -x - y; n2 = x - y;  end
        default: begin n1 = x + y;  n2 = -2 * y; end
      endcase
      bus = (bus_v == 0) ? 64'd1 : bus_v;     // zero bus acts as one
      s   = n1 + n2;
      den = longint'((2 * bus) << (VOLT_FRAC + 14));
      res.overmodulated = (s > den);
      if (s > den) den = s;
      lo  = count_of(64'(den - s), 64'(den));
      mid = count_of(64'(den - s + 2 * n1), 64'(den));
      hi  = count_of(64'(den + s), 64'(den));
      case (res.sector)
        SEC_1:   begin res.duty_a = lo[15:0];  res.duty_b = mid[15:0]; res.duty_c = hi[15:0];  end
        SEC_2:   begin res.duty_a = mid[15:0]; res.duty_b = lo[15:0];  res.duty_c = hi[15:0];  end
        SEC_3:   begin res.duty_a = hi[15:0];  res.duty_b = lo[15:0];  res.duty_c = mid[15:0]; end
        SEC_4:   begin res.duty_a = hi[15:0];  res.duty_b = mid[15:0]; res.duty_c = lo[15:0];  end
        SEC_5:   begin res.duty_a = mid[15:0]; res.duty_b = hi[15:0];  res.duty_c = lo[15:0];  end
        default: begin res.duty_a = lo[15:0];  res.duty_b = hi[15:0];  res.duty_c = mid[15:0]; end
      endcase
      duty_q.push_back(res);
      n_cmd++;
      if (res.overmodulated) n_over++;
      sec_seen[res.sector]++;
    endfunction

    // -1: nothing expected; otherwise a mask of mismatching fields
    function int check_result(input out_item_t got, output out_item_t want);
      int mask;
      if (duty_q.size() == 0) return -1;
      want = duty_q.pop_front();
      mask = 0;
      if (got.duty_a != want.duty_a) mask |= 1;
      if (got.duty_b != want.duty_b) mask |= 2;
      if (got.duty_c != want.duty_c) mask |= 4;
      if (got.sector != want.sector) mask |= 8;
      if (got.overmodulated != want.overmodulated) mask |= 16;
      return mask;
    endfunction

    function int pending();
      return duty_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dq_to_svm_duty_modulator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  duty_scoreboard sb;
  int             n_err;
  int             n_cfg;
  int             cycle_cnt;
  int             idle_pct;     // sender idle chance of the current phase

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: ends a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    n_err++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // Monitors sample at the edge, before the DUT's nonblocking updates land,
  // so every transaction is seen exactly as the DUT takes it.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_command(in_data);
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    out_item_t want;
    int        mask;
    if (rst_n && out_strobe) begin
      mask = sb.check_result(out_data, want);
      if (mask < 0) begin
        report("unexpected result, sector", out_data.sector, 0);
      end else begin
        if (mask[0]) report("duty_a", out_data.duty_a, want.duty_a);
        if (mask[1]) report("duty_b", out_data.duty_b, want.duty_b);
        if (mask[2]) report("duty_c", out_data.duty_c, want.duty_c);
        if (mask[3]) report("sector", out_data.sector, want.sector);
        if (mask[4]) report("overmodulated", out_data.overmodulated, want.overmodulated);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: each task starts and ends right after a rising edge
  // --------------------------------------------------------------------------
  task automatic send(input logic [15:0] ang, input logic [15:0] vd, input logic [15:0] vq);
    // each cycle idles with chance idle_pct; otherwise start stays high
    // across back-to-back transactions
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{angle: ang, volt_d: vd, volt_q: vq};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  // bus and full scale, plus a stray write to an unused index
  task automatic set_config(input logic [15:0] bus, input logic [15:0] fs);
    cfg_write(REG_BUS_VOLTAGE, bus);
    cfg_write(REG_PWM_FULL_SCALE, fs);
    cfg_write(CFG_IDX_W'(2 + $urandom_range(1)), 16'($urandom));
  endtask

  // mostly in-range commands, some full-range (overmodulated) noise
  task automatic send_random(input int span);
    logic [15:0] vd, vq;
    if ($urandom_range(99) < 25) begin
      vd = 16'($urandom);
      vq = 16'($urandom);
    end else begin
      vd = 16'($signed($urandom_range(2 * span)) - span);
      vq = 16'($signed($urandom_range(2 * span)) - span);
    end
    send(16'($urandom), vd, vq);
  endtask

  task automatic random_phase(input int n, input int pct, input int span);
    idle_pct = pct;
    repeat (n) send_random(span);
    drain();
  endtask

  initial begin
    sb        = new();
    n_err     = 0;
    n_cfg     = 0;
    cycle_cnt = 0;
    idle_pct  = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, field extremes, zero vector, each sector
    send(16'h0000, 16'h0000, 16'h0000);       // zero vector
    send(16'hFFFF, 16'h7FFF, 16'h7FFF);
    send(16'h0000, 16'h8000, 16'h8000);
    send(16'h00FF, 16'h7FFF, 16'h8000);
    send(16'hFF80, 16'h8000, 16'h7FFF);       // last table entry wraps
    for (int k = 0; k < 6; k++) begin
      send(16'(k * 10923 + 5461), 16'd0, 16'd4000);
    end
    send(16'h4000, 16'd2000, 16'd0);
    send(16'h8000, 16'd0, 16'hF000);
    send(16'hC000, 16'd8000, 16'd8000);
    drain();

    // extremes of the registers, including zero bus and zero full scale
    set_config(16'h7FFF, 16'hFFFF);
    send(16'h1234, 16'h7FFF, 16'h8000);
    send(16'hABCD, 16'h0100, 16'hFF00);
    drain();
    set_config(16'h0000, 16'h0000);           // zero bus, zero full scale
    send(16'h2000, 16'h0001, 16'h0001);
    send(16'h6000, 16'h0000, 16'h0000);
    drain();
    set_config(16'hFFFF, 16'd1);              // bus data above 15 bits
    send(16'h3000, 16'h0100, 16'h0200);
    send(16'h9000, 16'h8000, 16'h0000);
    drain();

    // random phases over a spread of settings and idle rates
    set_config(16'd24576, 16'd10000);
    random_phase(300, 0, 24000);
    set_config(16'd1, 16'hFFFF);
    random_phase(150, 64, 4);
    set_config(16'h7FFF, 16'($urandom_range(1, 65535)));
    random_phase(300, 64, 32767);
    set_config(16'($urandom_range(1, 32767)), 16'($urandom_range(1, 65535)));
    random_phase(300, 0, 16000);
    set_config(16'($urandom_range(100, 3000)), 16'($urandom));
    random_phase(300, 14, 6000);

    $display("covered %0d commands (%0d overmodulated), %0d config writes",
             sb.n_cmd, sb.n_over, n_cfg);
    $display("sectors 1..6 hit %0d %0d %0d %0d %0d %0d, mismatches %0d",
             sb.sec_seen[1], sb.sec_seen[2], sb.sec_seen[3],
             sb.sec_seen[4], sb.sec_seen[5], sb.sec_seen[6], n_err);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
